>>> hw/rtl/npci_pkg.sv
// Shared types, codes and the colour distance function of the nearest palette colour search.
package npci_pkg;

  // Command codes carried by an input transaction.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Largest Manhattan distance between two RGB888 colours (255+255+255).
  localparam logic [9:0] MAX_DISTANCE = 10'd765;

  // Reset value of the entries-in-use register.
  localparam logic [8:0] ENTRIES_RESET = 9'd256;

  // Input transaction.
  typedef struct packed {
    logic        command;
    logic [7:0]  entry_index;
    logic [23:0] color;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [7:0] best_index;
    logic       found;
    logic       exact_match;
    logic [9:0] best_distance;
  } out_item_t;

  // Search state handed from one cell to the next.
  typedef struct packed {
    logic [23:0] color;
    logic        found;
    logic [9:0]  best_distance;
    logic [7:0]  best_index;
  } query_tok_t;

  // Absolute difference of two 8-bit channels.
  function automatic logic [7:0] chan_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

  // Sum of the absolute red, green and blue differences.
  function automatic logic [9:0] color_distance(input logic [23:0] p, input logic [23:0] q);
    logic [9:0] dr;
    logic [9:0] dg;
    logic [9:0] db;
    dr = {2'b00, chan_diff(p[23:16], q[23:16])};
    dg = {2'b00, chan_diff(p[15:8], q[15:8])};
    db = {2'b00, chan_diff(p[7:0], q[7:0])};
    return dr + dg + db;
  endfunction

endpackage

>>> hw/rtl/npci_cell.sv
// One palette cell: holds a single entry and refines the passing search state.
module npci_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [7:0]             wr_index,
  input  logic [23:0]            wr_color,
  input  logic [8:0]             count,
  input  logic                   tok_valid_in,
  input  npci_pkg::query_tok_t   tok_in,
  output logic                   tok_valid_out,
  output npci_pkg::query_tok_t   tok_out
);

  // Only the first 256 slots can be addressed or searched.
  localparam bit         IN_RANGE = (CELL_IDX < 256);
  localparam logic [7:0] IDX8     = 8'(CELL_IDX % 256);
  localparam logic [8:0] IDX9     = {1'b0, IDX8};

  logic [23:0]          entry_r;
  logic                 valid_r;
  npci_pkg::query_tok_t tok_r;
  npci_pkg::query_tok_t tok_nxt;
  logic                 active;
  logic [9:0]           cell_distance;
  logic                 take;

  // Store the palette entry when a write addresses this slot.
  always_ff @(posedge clk) begin
    if (wr_en && IN_RANGE && (wr_index == IDX8)) begin
      entry_r <= wr_color;
    end
  end

  // The cell competes only when its slot lies below the entries in use.
  assign active        = IN_RANGE && (count > IDX9);
  assign cell_distance = npci_pkg::color_distance(entry_r, tok_in.color);
  assign take          = active && (!tok_in.found || (cell_distance < tok_in.best_distance));

  // A strictly smaller distance replaces the best so far, so ties keep the earlier slot.
  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found         = 1'b1;
      tok_nxt.best_distance = cell_distance;
      tok_nxt.best_index    = IDX8;
    end
  end

  // Hand the search state on to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tok_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_valid_out = valid_r;
  assign tok_out       = tok_r;

endmodule

>>> hw/rtl/nearest_palette_color_index_top.sv
// Top level of the nearest palette colour search: command port, register and cell chain.
//
//   Channel  Ports                         Transfer
//   input    start, busy, in_item          accepted when start is high and busy is low
//   result   out_valid, out_item           one-cycle strobe, cannot be held off
//   config   cfg_valid, cfg_ready, cfg_data written when cfg_valid and cfg_ready are high
//
// A write transaction does not raise busy, so the block can take another transaction in the following cycle.
// A query walks the chain of PALETTE_DEPTH cells, one cell per cycle; its result strobes
// as it leaves the last cell, and the next transaction can be taken in the cycle after
// the strobe, so no new transaction is taken while a query is in flight.
// Synchronous active-low reset clears the chain's valid bits and busy and sets the register to 256;
// palette entries are undefined until written. Results are never stalled.
module nearest_palette_color_index_top #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  npci_pkg::in_item_t  in_item,
  output logic                out_valid,
  output npci_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [8:0]          cfg_data
);

  logic                 busy_r;
  logic                 busy_nxt;
  logic [8:0]           entries_in_use_r;
  logic                 in_accept;
  logic                 wr_en;
  logic                 query_go;
  logic                 chain_valid [PALETTE_DEPTH+1];
  npci_pkg::query_tok_t chain_tok   [PALETTE_DEPTH+1];
  npci_pkg::query_tok_t last_tok;

  // The register is only written while no query walks the chain and no transaction is
  // offered, so every cell of a query sees the same entry count.
  assign busy      = busy_r;
  assign cfg_ready = !busy_r && !start;
  assign in_accept = start && !busy_r;
  assign wr_en     = in_accept && (in_item.command == npci_pkg::CMD_WRITE);
  assign query_go  = in_accept && (in_item.command == npci_pkg::CMD_QUERY);

  // Entries-in-use register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= npci_pkg::ENTRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use_r <= cfg_data;
    end
  end

  // Busy from query acceptance until the result leaves the last cell.
  always_comb begin
    busy_nxt = busy_r;
    if (query_go) begin
      busy_nxt = 1'b1;
    end else if (chain_valid[PALETTE_DEPTH]) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // A query enters the chain with nothing found yet.
  assign chain_valid[0]             = query_go;
  assign chain_tok[0].color         = in_item.color;
  assign chain_tok[0].found         = 1'b0;
  assign chain_tok[0].best_distance = '0;
  assign chain_tok[0].best_index    = '0;

  // Chain of palette cells, one per slot.
  for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
    npci_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .wr_en        (wr_en),
      .wr_index     (in_item.entry_index),
      .wr_color     (in_item.color),
      .count        (entries_in_use_r),
      .tok_valid_in (chain_valid[g]),
      .tok_in       (chain_tok[g]),
      .tok_valid_out(chain_valid[g+1]),
      .tok_out      (chain_tok[g+1])
    );
  end

  // Result from the end of the chain.
  assign last_tok               = chain_tok[PALETTE_DEPTH];
  assign out_valid              = chain_valid[PALETTE_DEPTH];
  assign out_item.best_index    = last_tok.best_index;
  assign out_item.found         = last_tok.found;
  assign out_item.exact_match   = last_tok.found && (last_tok.best_distance == '0);
  assign out_item.best_distance = last_tok.best_distance;

`ifndef SYNTH
  // A result only appears while a query is in flight.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result strobe without a query in flight");

  // An accepted query keeps the block busy in the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    query_go |=> busy_r)
    else $error("busy not raised after query");

  // An empty search reports zero index and distance.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |->
      (out_item.best_index == '0 && out_item.best_distance == '0))
    else $error("empty search with non-zero result");

  // The reported distance never exceeds the largest possible one.
  a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.best_distance <= npci_pkg::MAX_DISTANCE))
    else $error("distance out of range");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the nearest palette colour search: directed table and random traffic.
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH      = 256;
  localparam int ITEM_GOAL  = 1500;
  localparam int RUN_LIMIT  = 1500000;
  localparam int MAX_SHOWN  = 10;
  localparam int PLAN_ROWS  = 22;

  // Rows of the directed table either set the entry count or carry one transaction.
  typedef enum logic {ROW_SET, ROW_CMD} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [8:0]          setting;
    npci_pkg::in_item_t  item;
    bit                  typed;
    npci_pkg::out_item_t want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  npci_pkg::in_item_t  cmd_bus;
  logic                out_valid;
  npci_pkg::out_item_t result_bus;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [8:0]          cfg_data;

  // Mirror of the palette and the entry count as the block should hold them.
  logic [23:0]         palette_mirror [DEPTH];
  bit [DEPTH-1:0]      slot_loaded;
  logic [8:0]          entries_setting;
  npci_pkg::out_item_t pending_results [$];

  int unsigned cycle_count = 0;
  int unsigned n_writes    = 0;
  int unsigned n_queries   = 0;
  int unsigned n_checked   = 0;
  int unsigned n_failures  = 0;
  int unsigned n_settings  = 0;
  npci_pkg::out_item_t want_now;

  // Directed table: empty palette, extremes of distance and slot, ties and exact hits.
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_SET, 9'd0, '0, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd0, 24'hFFFFFF}, 1'b1,
      '{8'd0, 1'b0, 1'b0, 10'd0}},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd255, 24'h000000}, 1'b1,
      '{8'd0, 1'b0, 1'b0, 10'd0}},
    '{ROW_SET, 9'd1, '0, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_WRITE, 8'd0, 24'h000000}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd0, 24'hFFFFFF}, 1'b1,
      '{8'd0, 1'b1, 1'b0, npci_pkg::MAX_DISTANCE}},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd0, 24'h000000}, 1'b1,
      '{8'd0, 1'b1, 1'b1, 10'd0}},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_WRITE, 8'd1, 24'hFFFFFF}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_WRITE, 8'd255, 24'hA5A5A5}, 1'b0, '0},
    '{ROW_SET, 9'd2, '0, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd0, 24'hFFFFFF}, 1'b1,
      '{8'd1, 1'b1, 1'b1, 10'd0}},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd0, 24'h808080}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd0, 24'h7F7F7F}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_WRITE, 8'd2, 24'h000000}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_WRITE, 8'd3, 24'h010203}, 1'b0, '0},
    '{ROW_SET, 9'd4, '0, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd0, 24'h000000}, 1'b1,
      '{8'd0, 1'b1, 1'b1, 10'd0}},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd0, 24'h010101}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd0, 24'h020202}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_WRITE, 8'd1, 24'hFF00FF}, 1'b0, '0},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd0, 24'hFF00FF}, 1'b1,
      '{8'd1, 1'b1, 1'b1, 10'd0}},
    '{ROW_CMD, 9'd0, '{npci_pkg::CMD_QUERY, 8'd0, 24'h00FF00}, 1'b0, '0}
  };

  nearest_palette_color_index_top #(
    .PALETTE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (cmd_bus),
    .out_valid(out_valid),
    .out_item (result_bus),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Number of slots a query walks, saturated at the store depth.
  function automatic int searched_slots();
    int n;
    n = entries_setting;
    if (n > DEPTH) n = DEPTH;
    if (n > 256) n = 256;
    return n;
  endfunction

  // First slot with the smallest Manhattan distance; the walk stops at an exact hit.
  function automatic npci_pkg::out_item_t nearest_entry(input logic [23:0] colour);
    npci_pkg::out_item_t r;
    int        n;
    int        d;
    int        dc;
    int        i;
    int        k;
    r = '0;
    n = searched_slots();
    for (i = 0; i < n; i++) begin
      d = 0;
      for (k = 0; k < 3; k++) begin
        dc = int'(palette_mirror[i][8*k +: 8]) - int'(colour[8*k +: 8]);
        d += (dc < 0) ? -dc : dc;
      end
      if (!r.found || d < int'(r.best_distance)) begin
        r.found         = 1'b1;
        r.best_distance = d[9:0];
        r.best_index    = i[7:0];
      end
      if (d == 0) break;
    end
    r.exact_match = r.found && (r.best_distance == 10'd0);
    return r;
  endfunction

  // Lowest slot not yet written since reset; DEPTH when all are loaded.
  function automatic int first_unloaded();
    int i;
    for (i = 0; i < DEPTH; i++) begin
      if (!slot_loaded[i]) return i;
    end
    return DEPTH;
  endfunction

  // Present one transaction after an idle gap and hold it until the block takes it.
  task automatic send_command(input npci_pkg::in_item_t it, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    cmd_bus <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Send a transaction and record its effect on the mirror or the expected results.
  task automatic issue(input npci_pkg::in_item_t it, input bit typed,
                       input npci_pkg::out_item_t want, input int unsigned gap);
    send_command(it, gap);
    if (it.command == npci_pkg::CMD_WRITE) begin
      palette_mirror[it.entry_index] = it.color;
      slot_loaded[it.entry_index]    = 1'b1;
      n_writes++;
    end else begin
      pending_results.push_back(typed ? want : nearest_entry(it.color));
      n_queries++;
    end
  endtask

  // Change the entry count once the block has drained and settled.
  task automatic set_entries(input logic [8:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid       <= 1'b0;
    entries_setting  = value;
    n_settings++;
  endtask

  // Check every result strobe against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        n_failures++;
        if (n_failures <= MAX_SHOWN)
          $display("Unexpected result: idx=%0d found=%0b exact=%0b dist=%0d",
                   result_bus.best_index, result_bus.found, result_bus.exact_match,
                   result_bus.best_distance);
      end else begin
        want_now = pending_results.pop_front();
        n_checked++;
        if (result_bus.best_index !== want_now.best_index ||
            result_bus.found !== want_now.found ||
            result_bus.exact_match !== want_now.exact_match ||
            result_bus.best_distance !== want_now.best_distance) begin
          n_failures++;
          if (n_failures <= MAX_SHOWN) begin
            $display("Result %0d wrong: expected idx=%0d found=%0b exact=%0b dist=%0d",
                     n_checked, want_now.best_index, want_now.found,
                     want_now.exact_match, want_now.best_distance);
            $display("  got idx=%0d found=%0b exact=%0b dist=%0d",
                     result_bus.best_index, result_bus.found,
                     result_bus.exact_match, result_bus.best_distance);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("Run timed out after %0d cycles", cycle_count);
    $display("nearest_palette_color_index_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]          levels [5];
    npci_pkg::in_item_t  it;
    int unsigned         gap;
    int unsigned         phase_len;
    int unsigned         phase;
    int                  reach;
    int                  hole;
    bit                  steady;
    logic [8:0]          setting;
    int                  row;

    levels = '{8'h00, 8'h40, 8'h80, 8'hC0, 8'hFF};
    rst_n           = 1'b0;
    start           = 1'b0;
    cmd_bus         = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    slot_loaded     = '0;
    entries_setting = npci_pkg::ENTRIES_RESET;
    foreach (palette_mirror[i]) palette_mirror[i] = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (row = 0; row < PLAN_ROWS; row++) begin
      if (directed_plan[row].kind == ROW_SET)
        set_entries(directed_plan[row].setting);
      else
        issue(directed_plan[row].item, directed_plan[row].typed, directed_plan[row].want,
              $urandom_range(0, 3));
    end

    // Random phases, each under one entry count, the extremes among them.
    phase = 0;
    while (n_writes + n_queries < ITEM_GOAL) begin
      case (phase % 8)
        0: setting = 9'd256;
        1: setting = 9'd511;
        2: setting = 9'd1;
        3: setting = 9'($urandom_range(2, 12));
        4: setting = 9'd0;
        5: setting = 9'd257;
        6: setting = 9'($urandom_range(0, 511));
        default: setting = 9'($urandom_range(13, 255));
      endcase
      set_entries(setting);
      steady    = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 140);
      repeat (phase_len) begin
        reach = searched_slots();
        hole  = first_unloaded();
        it    = '0;
        if ($urandom_range(0, 9) < 6 && reach <= hole) begin
          // Query: copies of stored colours, near misses and arbitrary colours.
          it.command     = npci_pkg::CMD_QUERY;
          it.entry_index = 8'($urandom);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: it.color = (reach == 0) ? 24'($urandom)
                                   : palette_mirror[$urandom_range(0, reach - 1)];
            4, 5, 6:    it.color = ((reach == 0) ? 24'($urandom)
                                   : palette_mirror[$urandom_range(0, reach - 1)])
                                   ^ {5'd0, 3'($urandom), 5'd0, 3'($urandom),
                                      5'd0, 3'($urandom)};
            7:          it.color = {levels[$urandom_range(0, 4)], levels[$urandom_range(0, 4)],
                                    levels[$urandom_range(0, 4)]};
            default:    it.color = 24'($urandom);
          endcase
        end else begin
          // Write: usually to the lowest unwritten slot while one is left, else anywhere.
          it.command     = npci_pkg::CMD_WRITE;
          it.entry_index = (hole < DEPTH && $urandom_range(0, 9) < 7) ? 8'(hole)
                                                                      : 8'($urandom);
          case ($urandom_range(0, 9))
            0, 1, 2: it.color = {levels[$urandom_range(0, 4)], levels[$urandom_range(0, 4)],
                                 levels[$urandom_range(0, 4)]};
            3, 4:    it.color = palette_mirror[$urandom_range(0, DEPTH - 1)];
            default: it.color = 24'($urandom);
          endcase
        end
        gap = steady ? 0 : $urandom_range(0, 19);
        issue(it, 1'b0, '0, gap);
      end
      phase++;
    end
    start <= 1'b0;

    // Drain, then allow the walk time of one more query.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("Ran %0d palette writes and %0d queries across %0d entry-count settings.",
             n_writes, n_queries, n_settings);
    $display("Checked %0d results; %0d failures, %0d still outstanding.",
             n_checked, n_failures, pending_results.size());
    if (n_failures == 0 && pending_results.size() == 0) begin
      $display("nearest_palette_color_index_top: match");
    end else begin
      $display("nearest_palette_color_index_top: mismatch");
    end
    $finish;
  end

endmodule
